// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types, codes and constants for the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_W        = 32;
    localparam int FUNC_W       = 2;
    localparam int STAT_W       = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_PEEK   = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_ROOT,
        S_LAST,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_RES
    } t_state;

    typedef enum logic [2:0] {
        RD_ROOT,
        RD_PARENT,
        RD_LAST,
        RD_LC,
        RD_RC
    } t_rd_src;

    typedef enum logic [1:0] {
        WR_HOLD,
        WR_RDATA,
        WR_BEST
    } t_wr_src;

    typedef enum logic [1:0] {
        POS_KEEP,
        POS_PARENT,
        POS_BEST,
        POS_ZERO
    } t_pos_src;

    typedef struct packed {
        logic     in_ld;        // hold <= input key, pos <= count
        logic     cnt_inc;
        logic     cnt_dec;
        logic     rd_en;
        t_rd_src  rd_src;
        logic     wr_en;
        t_wr_src  wr_src;
        t_pos_src pos_src;
        logic     hold_ld;      // hold <= read data
        logic     lkey_ld;      // left child key <= read data
        logic     pend_ld;      // pending result <= status (and read data if ok)
        t_status  pend_status;
        logic     res_push;     // pending result -> output register
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic up_less;
        logic dn_leaf;
        logic dn_move;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/mhpq_req_if.sv =====
// ----------------------------------------------------------------------------
// mhpq_req_if
// Request channel: operation code and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhpq_req_if
    import mhpq_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

// ===== rtl/mhpq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mhpq_rsp_if
// Response channel: minimum key and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhpq_rsp_if
    import mhpq_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] min_key;
    logic [STAT_W-1:0]       status;

    modport source (output valid, output min_key, output status, input ready);
    modport sink   (input valid, input min_key, input status, output ready);
endinterface

// ===== rtl/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for insert (sift up), delete (sift down) and peek.
// ----------------------------------------------------------------------------
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [FUNC_W-1:0] i_req_func,
    output logic              o_req_ready,
    input  t_dp_sts           i_sts,
    output t_dp_cmd           o_cmd
);

    t_state r_state, n_state;
    logic   r_del, n_del;
    logic   w_acc;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_acc       = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_del   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_del   <= n_del;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_del   = r_del;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_del = (i_req_func == FN_DELETE);
                    case (i_req_func)
                        FN_INSERT: n_state = i_sts.full ? S_RES : S_UP_CHK;
                        FN_DELETE,
                        FN_PEEK:   n_state = i_sts.empty ? S_RES : S_ROOT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_UP_CHK: n_state = i_sts.pos_zero ? S_IDLE : S_UP_CMP;
            S_UP_CMP: n_state = i_sts.up_less ? S_UP_CHK : S_IDLE;
            S_ROOT:   n_state = r_del ? S_LAST : S_RES;
            S_LAST:   n_state = S_DN_RDL;
            S_DN_RDL: n_state = i_sts.dn_leaf ? S_RES : S_DN_RDR;
            S_DN_RDR: n_state = S_DN_CMP;
            S_DN_CMP: n_state = i_sts.dn_move ? S_DN_RDL : S_RES;
            S_RES:    n_state = i_sts.out_free ? S_IDLE : S_RES;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        o_cmd.rd_src      = RD_ROOT;
        o_cmd.wr_src      = WR_HOLD;
        o_cmd.pos_src     = POS_KEEP;
        o_cmd.pend_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req_func)
                        FN_INSERT: begin
                            if (i_sts.full) begin
                                o_cmd.pend_ld     = 1'b1;
                                o_cmd.pend_status = ST_FULL;
                            end else begin
                                o_cmd.in_ld   = 1'b1;
                                o_cmd.cnt_inc = 1'b1;
                            end
                        end
                        FN_DELETE,
                        FN_PEEK: begin
                            if (i_sts.empty) begin
                                o_cmd.pend_ld     = 1'b1;
                                o_cmd.pend_status = ST_EMPTY;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_src = RD_ROOT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_UP_CHK: begin
                if (i_sts.pos_zero) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_src = WR_HOLD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_PARENT;
                end
            end
            S_UP_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.up_less) begin
                    o_cmd.wr_src  = WR_RDATA;   // parent moves down
                    o_cmd.pos_src = POS_PARENT;
                end else begin
                    o_cmd.wr_src = WR_HOLD;
                end
            end
            S_ROOT: begin
                o_cmd.pend_ld     = 1'b1;
                o_cmd.pend_status = ST_OK;
                if (r_del) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_src  = RD_LAST;
                    o_cmd.cnt_dec = 1'b1;
                end
            end
            S_LAST: begin
                o_cmd.hold_ld = 1'b1;
                o_cmd.pos_src = POS_ZERO;
            end
            S_DN_RDL: begin
                if (i_sts.dn_leaf) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_src = WR_HOLD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_LC;
                end
            end
            S_DN_RDR: begin
                o_cmd.lkey_ld = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_src  = RD_RC;
            end
            S_DN_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.dn_move) begin
                    o_cmd.wr_src  = WR_BEST;
                    o_cmd.pos_src = POS_BEST;
                end else begin
                    o_cmd.wr_src = WR_HOLD;
                end
            end
            S_RES: begin
                o_cmd.res_push = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/mhpq_dp.sv =====
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap storage, sift position/key registers, compares and result register.
// ----------------------------------------------------------------------------
module mhpq_dp
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [KEY_W-1:0] i_key,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [KEY_W-1:0] o_min_key,
    output logic [STAT_W-1:0]       o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;   // child index, up to 2*CAPACITY

    logic [KEY_W-1:0] mem [CAPACITY];

    logic [CW-1:0]           r_count;
    logic [AW-1:0]           r_pos;
    logic signed [KEY_W-1:0] r_hold;
    logic signed [KEY_W-1:0] r_lkey;
    logic signed [KEY_W-1:0] r_rdata;
    logic signed [KEY_W-1:0] r_pend_key;
    t_status                 r_pend_status;
    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_out_key;
    t_status                 r_out_status;

    logic [AW-1:0]           w_pos_m1;
    logic [AW-1:0]           w_parent;
    logic [CW-1:0]           w_cnt_m1;
    logic [XW-1:0]           w_lc;
    logic [XW-1:0]           w_rc;
    logic [XW-1:0]           w_cnt_x;
    logic                    w_rc_ok;
    logic                    w_lless;
    logic signed [KEY_W-1:0] w_lmin;
    logic                    w_rless;
    logic signed [KEY_W-1:0] w_best_key;
    logic [AW-1:0]           w_best_pos;
    logic [AW-1:0]           w_rd_addr;
    logic [KEY_W-1:0]        w_wr_data;
    logic                    w_out_free;

    assign w_pos_m1 = r_pos - AW'(1);
    assign w_parent = w_pos_m1 >> 1;
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_lc     = {1'b0, r_pos, 1'b1};
    assign w_rc     = w_lc + XW'(1);
    assign w_cnt_x  = {{(XW-CW){1'b0}}, r_count};
    assign w_rc_ok  = (w_rc < w_cnt_x);

    // pick the smaller child if it beats the moving key; left wins a tie
    assign w_lless    = (r_lkey < r_hold);
    assign w_lmin     = w_lless ? r_lkey : r_hold;
    assign w_rless    = w_rc_ok && (r_rdata < w_lmin);
    assign w_best_key = w_rless ? r_rdata : r_lkey;
    assign w_best_pos = w_rless ? w_rc[AW-1:0] : w_lc[AW-1:0];

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        case (i_cmd.rd_src)
            RD_ROOT:   w_rd_addr = '0;
            RD_PARENT: w_rd_addr = w_parent;
            RD_LAST:   w_rd_addr = w_cnt_m1[AW-1:0];
            RD_LC:     w_rd_addr = w_lc[AW-1:0];
            RD_RC:     w_rd_addr = w_rc[AW-1:0];
            default:   w_rd_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_src)
            WR_HOLD:  w_wr_data = r_hold;
            WR_RDATA: w_wr_data = r_rdata;
            WR_BEST:  w_wr_data = w_best_key;
            default:  w_wr_data = r_hold;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_pos] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= w_cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ld) begin
            r_hold <= i_key;
        end else if (i_cmd.hold_ld) begin
            r_hold <= r_rdata;
        end
        if (i_cmd.in_ld) begin
            r_pos <= r_count[AW-1:0];
        end else begin
            case (i_cmd.pos_src)
                POS_KEEP:   r_pos <= r_pos;
                POS_PARENT: r_pos <= w_parent;
                POS_BEST:   r_pos <= w_best_pos;
                POS_ZERO:   r_pos <= '0;
                default:    r_pos <= r_pos;
            endcase
        end
        if (i_cmd.lkey_ld) begin
            r_lkey <= r_rdata;
        end
        if (i_cmd.pend_ld) begin
            r_pend_status <= i_cmd.pend_status;
            r_pend_key    <= (i_cmd.pend_status == ST_OK) ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_push) begin
            r_out_key    <= r_pend_key;
            r_out_status <= r_pend_status;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_min_key = r_out_key;
    assign o_status  = r_out_status;

    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.up_less  = (r_hold < r_rdata);
    assign o_sts.dn_leaf  = !(w_lc < w_cnt_x);
    assign o_sts.dn_move  = w_lless || w_rless;
    assign o_sts.out_free = w_out_free;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_cnt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.cnt_inc && i_cmd.cnt_dec))
        else $error("count incremented and decremented together");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_push |-> (!r_out_valid || i_ready))
        else $error("result pushed over an untaken result");

    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_push |=> r_out_valid)
        else $error("pushed result not presented");

    a_rw_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.rd_en) |-> (w_rd_addr != r_pos))
        else $error("read and write to the same slot in one cycle");

endmodule

// ===== rtl/min_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top
// Binary min-heap priority queue of signed 32-bit keys.
// ----------------------------------------------------------------------------
// Each request transaction is insert, delete-min or peek-min; an unused code
// is taken and ignored. One request is worked at a time on a single-port
// heap memory (one read or one write per cycle, registered read). Insert
// sifts up by reading the parent, then comparing and writing, at each level,
// and gives no response unless the heap is full. Delete reads the root and
// the last key, then sifts down at each level by reading the left child,
// reading the right child, then comparing and writing. Full and empty cases
// answer with a status and no heap access. The per-level cost is set by the
// memory read latency on the sift loop. A response waits in an output
// register, so the next request is taken while the previous response is
// still not taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (i_req.key),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_valid   (o_rsp.valid),
        .i_ready   (o_rsp.ready),
        .o_min_key (o_rsp.min_key),
        .o_status  (o_rsp.status)
    );

endmodule

// ===== tb/sv/tb_min_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue_top
// Self-checking bench for the min-heap priority queue. A directed pass covers
// the empty and ignored cases, the key extremes and equal keys. Random traffic
// then churns near empty, fills the heap past full and mixes at depth. A
// shadow heap predicts every response, and random gaps on both channels
// move the handshakes around.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue_top
    import mhpq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                      HEAP_CAP  = CAPACITY_DEF;
    localparam logic [FUNC_W-1:0]       FN_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_LOW   = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_HIGH  = ~KEY_LOW;

    typedef struct packed {
        logic signed [KEY_W-1:0] min_key;
        t_status                 status;
    } t_heap_answer;

    class t_heap_scoreboard;
        logic signed [KEY_W-1:0] slots [HEAP_CAP];
        int unsigned             fill;
        t_heap_answer            answers [$];
        int                      mismatches;

        // advance the shadow heap by one accepted request transaction
        function void note_request(logic [FUNC_W-1:0] op, logic signed [KEY_W-1:0] k);
            int unsigned             pos;
            int unsigned             up;
            int unsigned             lc;
            int unsigned             best;
            logic signed [KEY_W-1:0] tmp;
            case (op)
                FN_INSERT: begin
                    if (fill >= HEAP_CAP) begin
                        answers.push_back('{min_key: '0, status: ST_FULL});
                    end else begin
                        slots[fill] = k;
                        pos = fill;
                        while (pos > 0) begin
                            up = (pos - 1) / 2;
                            if (slots[pos] < slots[up]) begin
                                tmp = slots[pos];
                                slots[pos] = slots[up];
                                slots[up] = tmp;
                                pos = up;
                            end else begin
                                break;
                            end
                        end
                        fill++;
                    end
                end
                FN_DELETE, FN_PEEK: begin
                    if (fill == 0) begin
                        answers.push_back('{min_key: '0, status: ST_EMPTY});
                    end else begin
                        answers.push_back('{min_key: slots[0], status: ST_OK});
                        if (op == FN_DELETE) begin
                            slots[0] = slots[fill-1];
                            fill--;
                            pos = 0;
                            // left child wins a tie: only strictly smaller moves
                            while (1) begin
                                lc = 2 * pos + 1;
                                best = pos;
                                if (lc < fill && slots[lc] < slots[best]) best = lc;
                                if (lc + 1 < fill && slots[lc+1] < slots[best]) best = lc + 1;
                                if (best == pos) break;
                                tmp = slots[pos];
                                slots[pos] = slots[best];
                                slots[best] = tmp;
                                pos = best;
                            end
                        end
                    end
                end
                default: ;  // unused code: no state change, no response
            endcase
        endfunction

        function void check_response(logic signed [KEY_W-1:0] k, logic [STAT_W-1:0] st);
            t_heap_answer want;
            bit           stray;
            stray = (answers.size() == 0);
            if (!stray) want = answers.pop_front();
            if (stray || k !== want.min_key || st !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    if (stray)
                        $display("response with none expected: min_key %0d status %0d",
                                 k, st);
                    else
                        $display({"response mismatch: expected min_key %0d status %0d,",
                                  " got min_key %0d status %0d"},
                                 want.min_key, want.status, k, st);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mhpq_req_if req_if ();
    mhpq_rsp_if rsp_if ();

    t_heap_scoreboard sb = new;
    int               send_calm;

    min_heap_priority_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // full range, a narrow band with many repeats, and the extremes
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return $urandom_range(0, 40) - 20;
            7: begin
                case ($urandom_range(0, 3))
                    0:       return KEY_LOW;
                    1:       return KEY_HIGH;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:       return $urandom_range(0, 7) - 4;
        endcase
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] op, input logic signed [KEY_W-1:0] k);
        int gap;
        gap = 0;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(20, 120);
        else gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            req_if.func  <= FUNC_W'($urandom);
            req_if.key   <= $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.func  <= op;
        req_if.key   <= k;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(op, k);
    endtask

    // to_full: run until several inserts have met a full heap
    task automatic run_mix(input int n, input int ins_pct, input int del_pct, input bit to_full);
        int                done;
        int                full_seen;
        int                r;
        logic [FUNC_W-1:0] op;
        done = 0;
        full_seen = 0;
        while (to_full ? (full_seen < 8) : (done < n)) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) op = FN_INSERT;
            else if (r < ins_pct + del_pct) op = FN_DELETE;
            else if (r < 97) op = FN_PEEK;
            else op = FN_UNUSED;
            if (op == FN_INSERT && sb.fill == HEAP_CAP) full_seen++;
            send_request(op, pick_key());
            if (op != FN_UNUSED) done++;
        end
    endtask

    // response side back-pressure
    initial begin
        int stall_left;
        int calm_left;
        rsp_if.ready = 1'b0;
        stall_left = 0;
        calm_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                if (calm_left > 0) calm_left--;
                else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 120);
                else stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.min_key, rsp_if.status);
    end

    initial begin
        #1_600_000;
        $display("tb_min_heap_priority_queue_top: errors");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.func  = FN_INSERT;
        req_if.key   = '0;
        send_calm    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty heap, ignored code, extremes, equal keys, drain past empty
        send_request(FN_PEEK, '0);
        send_request(FN_DELETE, '1);
        send_request(FN_UNUSED, KEY_LOW);
        send_request(FN_INSERT, KEY_HIGH);
        send_request(FN_INSERT, KEY_LOW);
        send_request(FN_PEEK, '0);
        send_request(FN_INSERT, '0);
        send_request(FN_INSERT, '1);
        send_request(FN_INSERT, 32'sd5);
        send_request(FN_INSERT, 32'sd5);
        send_request(FN_INSERT, 32'sd3);
        send_request(FN_UNUSED, KEY_HIGH);
        repeat (4) send_request(FN_DELETE, '0);
        send_request(FN_PEEK, '0);
        repeat (4) send_request(FN_DELETE, '0);
        send_request(FN_PEEK, '0);

        run_mix(60, 45, 45, 1'b0);
        run_mix(0, 90, 5, 1'b1);
        run_mix(90, 35, 50, 1'b0);

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.answers.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.answers.size() == 0)
            $display("tb_min_heap_priority_queue_top: clean");
        else
            $display("tb_min_heap_priority_queue_top: errors");
        $finish;
    end

endmodule
